FILE: hdl/lrk4_pkg.sv
package lrk4_pkg;

  // Number format: signed Q11.20 in one 32-bit word
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 20;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Register reset values
  localparam logic [30:0] SIGMA_RESET = 31'd10485760;
  localparam logic [30:0] RHO_RESET   = 31'd29360128;
  localparam logic [30:0] BETA_RESET  = 31'd2796203;
  localparam logic [30:0] DT_RESET    = 31'd104858;
  localparam word_t       START_RESET = 32'sd10485760;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SIGMA   = 3'd0;
  localparam logic [2:0] REG_RHO     = 3'd1;
  localparam logic [2:0] REG_BETA    = 3'd2;
  localparam logic [2:0] REG_DT      = 3'd3;
  localparam logic [2:0] REG_START_X = 3'd4;
  localparam logic [2:0] REG_START_Y = 3'd5;
  localparam logic [2:0] REG_START_Z = 3'd6;

  // Reciprocal for divide by 3 and by 6 of a 32-bit unsigned value
  localparam logic [31:0] RECIP3     = 32'hAAAAAAAB;
  localparam int          DIV3_SHIFT = 33;
  localparam int          DIV6_SHIFT = 34;

  // Operations of the shared unit
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV3,
    OP_DIV6
  } op_kind_e;

  // Operand and destination codes
  typedef enum logic [4:0] {
    R_PX, R_PY, R_PZ,
    R_QX, R_QY, R_QZ,
    R_DX, R_DY, R_DZ,
    R_KX, R_KY, R_KZ,
    R_VX, R_VY, R_VZ,
    R_T0, R_T1,
    R_H3, R_H6, R_HH, R_DT,
    R_SG, R_RG, R_BG
  } opnd_e;

  typedef struct packed {
    op_kind_e kind;
    opnd_e    src_a;
    opnd_e    src_b;
    opnd_e    dst;
  } op_t;

  localparam int PROG_LEN  = 80;
  localparam int PC_BITS   = $clog2(PROG_LEN);
  localparam logic [PC_BITS-1:0] PROG_LAST = PC_BITS'(PROG_LEN - 1);

  // Micro-program of one RK4 step. The probe point Q holds P at the start.
  function automatic op_t prog_op(input logic [PC_BITS-1:0] pc);
    op_t r;
    begin
      case (pc)
        // step fractions dt/3 and dt/6
        7'd0:  r = '{OP_DIV3, R_DT, R_DT, R_H3};
        7'd1:  r = '{OP_DIV6, R_DT, R_DT, R_H6};
        // k1 = f(Q)
        7'd2:  r = '{OP_SUB, R_QY, R_QX, R_T0};
        7'd3:  r = '{OP_MUL, R_SG, R_T0, R_KX};
        7'd4:  r = '{OP_MUL, R_RG, R_QX, R_T0};
        7'd5:  r = '{OP_SUB, R_T0, R_QY, R_T0};
        7'd6:  r = '{OP_MUL, R_QX, R_QZ, R_T1};
        7'd7:  r = '{OP_SUB, R_T0, R_T1, R_KY};
        7'd8:  r = '{OP_MUL, R_QX, R_QY, R_T0};
        7'd9:  r = '{OP_MUL, R_BG, R_QZ, R_T1};
        7'd10: r = '{OP_SUB, R_T0, R_T1, R_KZ};
        // V = P + dt/6 * k1
        7'd11: r = '{OP_MUL, R_H6, R_KX, R_T0};
        7'd12: r = '{OP_ADD, R_PX, R_T0, R_VX};
        7'd13: r = '{OP_MUL, R_H6, R_KY, R_T0};
        7'd14: r = '{OP_ADD, R_PY, R_T0, R_VY};
        7'd15: r = '{OP_MUL, R_H6, R_KZ, R_T0};
        7'd16: r = '{OP_ADD, R_PZ, R_T0, R_VZ};
        // Q = P + dt/2 * k1
        7'd17: r = '{OP_MUL, R_HH, R_KX, R_T0};
        7'd18: r = '{OP_ADD, R_PX, R_T0, R_QX};
        7'd19: r = '{OP_MUL, R_HH, R_KY, R_T0};
        7'd20: r = '{OP_ADD, R_PY, R_T0, R_QY};
        7'd21: r = '{OP_MUL, R_HH, R_KZ, R_T0};
        7'd22: r = '{OP_ADD, R_PZ, R_T0, R_QZ};
        // k2 = f(Q)
        7'd23: r = '{OP_SUB, R_QY, R_QX, R_T0};
        7'd24: r = '{OP_MUL, R_SG, R_T0, R_DX};
        7'd25: r = '{OP_MUL, R_RG, R_QX, R_T0};
        7'd26: r = '{OP_SUB, R_T0, R_QY, R_T0};
        7'd27: r = '{OP_MUL, R_QX, R_QZ, R_T1};
        7'd28: r = '{OP_SUB, R_T0, R_T1, R_DY};
        7'd29: r = '{OP_MUL, R_QX, R_QY, R_T0};
        7'd30: r = '{OP_MUL, R_BG, R_QZ, R_T1};
        7'd31: r = '{OP_SUB, R_T0, R_T1, R_DZ};
        // V += dt/3 * k2
        7'd32: r = '{OP_MUL, R_H3, R_DX, R_T0};
        7'd33: r = '{OP_ADD, R_VX, R_T0, R_VX};
        7'd34: r = '{OP_MUL, R_H3, R_DY, R_T0};
        7'd35: r = '{OP_ADD, R_VY, R_T0, R_VY};
        7'd36: r = '{OP_MUL, R_H3, R_DZ, R_T0};
        7'd37: r = '{OP_ADD, R_VZ, R_T0, R_VZ};
        // Q = P + dt/2 * k2
        7'd38: r = '{OP_MUL, R_HH, R_DX, R_T0};
        7'd39: r = '{OP_ADD, R_PX, R_T0, R_QX};
        7'd40: r = '{OP_MUL, R_HH, R_DY, R_T0};
        7'd41: r = '{OP_ADD, R_PY, R_T0, R_QY};
        7'd42: r = '{OP_MUL, R_HH, R_DZ, R_T0};
        7'd43: r = '{OP_ADD, R_PZ, R_T0, R_QZ};
        // k3 = f(Q)
        7'd44: r = '{OP_SUB, R_QY, R_QX, R_T0};
        7'd45: r = '{OP_MUL, R_SG, R_T0, R_DX};
        7'd46: r = '{OP_MUL, R_RG, R_QX, R_T0};
        7'd47: r = '{OP_SUB, R_T0, R_QY, R_T0};
        7'd48: r = '{OP_MUL, R_QX, R_QZ, R_T1};
        7'd49: r = '{OP_SUB, R_T0, R_T1, R_DY};
        7'd50: r = '{OP_MUL, R_QX, R_QY, R_T0};
        7'd51: r = '{OP_MUL, R_BG, R_QZ, R_T1};
        7'd52: r = '{OP_SUB, R_T0, R_T1, R_DZ};
        // V += dt/3 * k3
        7'd53: r = '{OP_MUL, R_H3, R_DX, R_T0};
        7'd54: r = '{OP_ADD, R_VX, R_T0, R_VX};
        7'd55: r = '{OP_MUL, R_H3, R_DY, R_T0};
        7'd56: r = '{OP_ADD, R_VY, R_T0, R_VY};
        7'd57: r = '{OP_MUL, R_H3, R_DZ, R_T0};
        7'd58: r = '{OP_ADD, R_VZ, R_T0, R_VZ};
        // Q = P + dt * k3
        7'd59: r = '{OP_MUL, R_DT, R_DX, R_T0};
        7'd60: r = '{OP_ADD, R_PX, R_T0, R_QX};
        7'd61: r = '{OP_MUL, R_DT, R_DY, R_T0};
        7'd62: r = '{OP_ADD, R_PY, R_T0, R_QY};
        7'd63: r = '{OP_MUL, R_DT, R_DZ, R_T0};
        7'd64: r = '{OP_ADD, R_PZ, R_T0, R_QZ};
        // k4 = f(Q)
        7'd65: r = '{OP_SUB, R_QY, R_QX, R_T0};
        7'd66: r = '{OP_MUL, R_SG, R_T0, R_DX};
        7'd67: r = '{OP_MUL, R_RG, R_QX, R_T0};
        7'd68: r = '{OP_SUB, R_T0, R_QY, R_T0};
        7'd69: r = '{OP_MUL, R_QX, R_QZ, R_T1};
        7'd70: r = '{OP_SUB, R_T0, R_T1, R_DY};
        7'd71: r = '{OP_MUL, R_QX, R_QY, R_T0};
        7'd72: r = '{OP_MUL, R_BG, R_QZ, R_T1};
        7'd73: r = '{OP_SUB, R_T0, R_T1, R_DZ};
        // V += dt/6 * k4
        7'd74: r = '{OP_MUL, R_H6, R_DX, R_T0};
        7'd75: r = '{OP_ADD, R_VX, R_T0, R_VX};
        7'd76: r = '{OP_MUL, R_H6, R_DY, R_T0};
        7'd77: r = '{OP_ADD, R_VY, R_T0, R_VY};
        7'd78: r = '{OP_MUL, R_H6, R_DZ, R_T0};
        7'd79: r = '{OP_ADD, R_VZ, R_T0, R_VZ};
        default: r = '{OP_MUL, R_T0, R_T0, R_T1};
      endcase
      return r;
    end
  endfunction

endpackage

FILE: hdl/lorenz_rk4_integrator.sv
// Lorenz system integrator: each accepted input beat advances the point
// (x, y, z) by one fourth-order Runge-Kutta step and returns one output beat
// holding the point before the step, the derivative there, and a flag that
// is set when any add, subtract or multiply of that step saturated. All
// values are signed Q11.20; products round to nearest, ties away from zero.
// A beat with restart set reloads the configured start point first. The
// arithmetic runs on one shared unit (one 32x32 multiplier and one 33-bit
// adder) stepped by an 80-entry micro-program: an add or subtract is
// written back from the op state, a multiply from a second state after the
// product register. Input stalls until the result is in the output
// register. A result may sit unread while the next step runs; the step
// then waits at its end until the output register is free.
module lorenz_rk4_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] pos_x_out_o,
  output logic signed [31:0] pos_y_out_o,
  output logic signed [31:0] pos_z_out_o,
  output logic signed [31:0] deriv_x_o,
  output logic signed [31:0] deriv_y_o,
  output logic signed [31:0] deriv_z_o,
  output logic        overflow_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OP   = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int PROD_BITS = 2 * lrk4_pkg::WORD_BITS;
  localparam int QUOT_BITS = PROD_BITS + 1 - lrk4_pkg::FRAC_BITS;

  // configuration registers
  logic [30:0]      sigma_q, rho_q, beta_q, dt_q;
  lrk4_pkg::word_t  start_x_q, start_y_q, start_z_q;

  // sequencer
  logic [1:0]                      state_q;
  logic [lrk4_pkg::PC_BITS-1:0]    pc_q;
  lrk4_pkg::op_t                   op_cur;
  logic                            sat_q;

  // working values
  lrk4_pkg::word_t px_q, py_q, pz_q;
  lrk4_pkg::word_t qx_q, qy_q, qz_q;
  lrk4_pkg::word_t dx_q, dy_q, dz_q;
  lrk4_pkg::word_t kx_q, ky_q, kz_q;
  lrk4_pkg::word_t vx_q, vy_q, vz_q;
  lrk4_pkg::word_t t0_q, t1_q, h3_q, h6_q;

  // shared unit
  lrk4_pkg::word_t        opa, opb;
  logic signed [32:0]     sum_w;
  logic                   add_ovf;
  lrk4_pkg::word_t        add_res;
  logic [31:0]            mul_a, mul_b;
  logic [PROD_BITS-1:0]   prod_q;
  logic                   neg_q;
  logic [PROD_BITS:0]     rnd_w;
  logic [QUOT_BITS-1:0]   quot_w, limit_w;
  logic                   mul_ovf;
  lrk4_pkg::word_t        mul_res;
  logic                   wr_en;
  lrk4_pkg::word_t        wr_data;
  logic                   sat_hit;

  // output register
  logic            out_valid_q;
  lrk4_pkg::word_t out_px_q, out_py_q, out_pz_q;
  lrk4_pkg::word_t out_dx_q, out_dy_q, out_dz_q;
  logic            out_ovf_q;

  logic in_fire, out_free, cfg_wr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q   <= lrk4_pkg::SIGMA_RESET;
      rho_q     <= lrk4_pkg::RHO_RESET;
      beta_q    <= lrk4_pkg::BETA_RESET;
      dt_q      <= lrk4_pkg::DT_RESET;
      start_x_q <= lrk4_pkg::START_RESET;
      start_y_q <= lrk4_pkg::START_RESET;
      start_z_q <= lrk4_pkg::START_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        lrk4_pkg::REG_SIGMA:   sigma_q   <= pwdata[30:0];
        lrk4_pkg::REG_RHO:     rho_q     <= pwdata[30:0];
        lrk4_pkg::REG_BETA:    beta_q    <= pwdata[30:0];
        lrk4_pkg::REG_DT:      dt_q      <= pwdata[30:0];
        lrk4_pkg::REG_START_X: start_x_q <= pwdata;
        lrk4_pkg::REG_START_Y: start_y_q <= pwdata;
        lrk4_pkg::REG_START_Z: start_z_q <= pwdata;
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    case (paddr[4:2])
      lrk4_pkg::REG_SIGMA:   prdata = {1'b0, sigma_q};
      lrk4_pkg::REG_RHO:     prdata = {1'b0, rho_q};
      lrk4_pkg::REG_BETA:    prdata = {1'b0, beta_q};
      lrk4_pkg::REG_DT:      prdata = {1'b0, dt_q};
      lrk4_pkg::REG_START_X: prdata = start_x_q;
      lrk4_pkg::REG_START_Y: prdata = start_y_q;
      lrk4_pkg::REG_START_Z: prdata = start_z_q;
      default:               prdata = '0;
    endcase
  end

  // operand fetch
  function automatic lrk4_pkg::word_t pick(input lrk4_pkg::opnd_e s);
    lrk4_pkg::word_t v;
    begin
      case (s)
        lrk4_pkg::R_PX: v = px_q;
        lrk4_pkg::R_PY: v = py_q;
        lrk4_pkg::R_PZ: v = pz_q;
        lrk4_pkg::R_QX: v = qx_q;
        lrk4_pkg::R_QY: v = qy_q;
        lrk4_pkg::R_QZ: v = qz_q;
        lrk4_pkg::R_DX: v = dx_q;
        lrk4_pkg::R_DY: v = dy_q;
        lrk4_pkg::R_DZ: v = dz_q;
        lrk4_pkg::R_KX: v = kx_q;
        lrk4_pkg::R_KY: v = ky_q;
        lrk4_pkg::R_KZ: v = kz_q;
        lrk4_pkg::R_VX: v = vx_q;
        lrk4_pkg::R_VY: v = vy_q;
        lrk4_pkg::R_VZ: v = vz_q;
        lrk4_pkg::R_T0: v = t0_q;
        lrk4_pkg::R_T1: v = t1_q;
        lrk4_pkg::R_H3: v = h3_q;
        lrk4_pkg::R_H6: v = h6_q;
        lrk4_pkg::R_HH: v = {2'b00, dt_q[30:1]};
        lrk4_pkg::R_DT: v = {1'b0, dt_q};
        lrk4_pkg::R_SG: v = {1'b0, sigma_q};
        lrk4_pkg::R_RG: v = {1'b0, rho_q};
        lrk4_pkg::R_BG: v = {1'b0, beta_q};
        default:        v = '0;
      endcase
      return v;
    end
  endfunction

  assign op_cur = lrk4_pkg::prog_op(pc_q);

  always_comb begin
    opa = pick(op_cur.src_a);
    opb = pick(op_cur.src_b);
  end

  // saturating add and subtract
  always_comb begin
    if (op_cur.kind == lrk4_pkg::OP_SUB) begin
      sum_w = {opa[31], opa} - {opb[31], opb};
    end else begin
      sum_w = {opa[31], opa} + {opb[31], opb};
    end
    add_ovf = sum_w[32] ^ sum_w[31];
    if (add_ovf) begin
      add_res = sum_w[32] ? lrk4_pkg::WORD_MIN : lrk4_pkg::WORD_MAX;
    end else begin
      add_res = sum_w[31:0];
    end
  end

  // multiplier inputs: magnitudes, or dividend and reciprocal
  always_comb begin
    case (op_cur.kind)
      lrk4_pkg::OP_DIV3: begin
        mul_a = {1'b0, dt_q} + 32'd1;
        mul_b = lrk4_pkg::RECIP3;
      end
      lrk4_pkg::OP_DIV6: begin
        mul_a = {1'b0, dt_q} + 32'd3;
        mul_b = lrk4_pkg::RECIP3;
      end
      default: begin
        mul_a = opa[31] ? 32'(-opa) : 32'(opa);
        mul_b = opb[31] ? 32'(-opb) : 32'(opb);
      end
    endcase
  end

  // round to nearest and saturate the registered product
  always_comb begin
    rnd_w   = {1'b0, prod_q} + ((PROD_BITS + 1)'(1) << (lrk4_pkg::FRAC_BITS - 1));
    quot_w  = rnd_w[PROD_BITS:lrk4_pkg::FRAC_BITS];
    limit_w = neg_q ? (QUOT_BITS)'(33'h080000000) : (QUOT_BITS)'(33'h07FFFFFFF);
    mul_ovf = (quot_w > limit_w);
    if (mul_ovf) begin
      mul_res = neg_q ? lrk4_pkg::WORD_MIN : lrk4_pkg::WORD_MAX;
    end else begin
      mul_res = neg_q ? -quot_w[31:0] : quot_w[31:0];
    end
  end

  // select the write-back value
  always_comb begin
    wr_en   = 1'b0;
    wr_data = add_res;
    sat_hit = 1'b0;
    case (state_q)
      ST_OP: begin
        if (op_cur.kind == lrk4_pkg::OP_ADD || op_cur.kind == lrk4_pkg::OP_SUB) begin
          wr_en   = 1'b1;
          sat_hit = add_ovf;
        end
      end
      ST_MUL2: begin
        wr_en = 1'b1;
        case (op_cur.kind)
          lrk4_pkg::OP_DIV3: wr_data = 32'(prod_q[PROD_BITS-1:lrk4_pkg::DIV3_SHIFT]);
          lrk4_pkg::OP_DIV6: wr_data = 32'(prod_q[PROD_BITS-1:lrk4_pkg::DIV6_SHIFT]);
          default: begin
            wr_data = mul_res;
            sat_hit = mul_ovf;
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      sat_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_OP;
            pc_q    <= '0;
            sat_q   <= 1'b0;
          end
        end
        ST_OP: begin
          if (wr_en) begin
            sat_q <= sat_q | sat_hit;
            if (pc_q == lrk4_pkg::PROG_LAST) begin
              state_q <= ST_DONE;
            end else begin
              pc_q <= pc_q + 1'b1;
            end
          end else begin
            state_q <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          sat_q <= sat_q | sat_hit;
          if (pc_q == lrk4_pkg::PROG_LAST) begin
            state_q <= ST_DONE;
          end else begin
            pc_q    <= pc_q + 1'b1;
            state_q <= ST_OP;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OP) begin
      prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      neg_q  <= opa[31] ^ opb[31];
    end
  end

  // point: reload on restart, advance at the end of the step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= lrk4_pkg::START_RESET;
      py_q <= lrk4_pkg::START_RESET;
      pz_q <= lrk4_pkg::START_RESET;
    end else if (in_fire && restart_i) begin
      px_q <= start_x_q;
      py_q <= start_y_q;
      pz_q <= start_z_q;
    end else if (state_q == ST_DONE && out_free) begin
      px_q <= vx_q;
      py_q <= vy_q;
      pz_q <= vz_q;
    end
  end

  // scratch values
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      qx_q <= restart_i ? start_x_q : px_q;
      qy_q <= restart_i ? start_y_q : py_q;
      qz_q <= restart_i ? start_z_q : pz_q;
    end else if (wr_en) begin
      case (op_cur.dst)
        lrk4_pkg::R_QX: qx_q <= wr_data;
        lrk4_pkg::R_QY: qy_q <= wr_data;
        lrk4_pkg::R_QZ: qz_q <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (op_cur.dst)
        lrk4_pkg::R_DX: dx_q <= wr_data;
        lrk4_pkg::R_DY: dy_q <= wr_data;
        lrk4_pkg::R_DZ: dz_q <= wr_data;
        lrk4_pkg::R_KX: kx_q <= wr_data;
        lrk4_pkg::R_KY: ky_q <= wr_data;
        lrk4_pkg::R_KZ: kz_q <= wr_data;
        lrk4_pkg::R_VX: vx_q <= wr_data;
        lrk4_pkg::R_VY: vy_q <= wr_data;
        lrk4_pkg::R_VZ: vz_q <= wr_data;
        lrk4_pkg::R_T0: t0_q <= wr_data;
        lrk4_pkg::R_T1: t1_q <= wr_data;
        lrk4_pkg::R_H3: h3_q <= wr_data;
        lrk4_pkg::R_H6: h6_q <= wr_data;
        default: ;
      endcase
    end
  end

  // output register: drop a taken beat, load a finished step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_px_q  <= px_q;
      out_py_q  <= py_q;
      out_pz_q  <= pz_q;
      out_dx_q  <= kx_q;
      out_dy_q  <= ky_q;
      out_dz_q  <= kz_q;
      out_ovf_q <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_out_o = out_px_q;
  assign pos_y_out_o = out_py_q;
  assign pos_z_out_o = out_pz_q;
  assign deriv_x_o   = out_dx_q;
  assign deriv_y_o   = out_dy_q;
  assign deriv_z_o   = out_dz_q;
  assign overflow_o  = out_ovf_q;

`ifndef SYNTHESIS
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_OP && pc_q == '0))
    else $error("accepted beat did not start the program");

  a_mul_from_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL2) |-> ($past(state_q) == ST_OP && $stable(pc_q)))
    else $error("multiply second cycle entered out of sequence");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OP || state_q == ST_MUL2) |-> (pc_q <= lrk4_pkg::PROG_LAST))
    else $error("program counter ran past the last op");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result shown without a finished step");

  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("finished step not handed to the output");
`endif

endmodule
